// ===== rtl/integer_to_ascii_formatter_unit_defines.svh =====
// assertion macros for the integer to ascii formatter
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// checked only outside reset
`define ITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked in every cycle, reset included
`define ITOA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/itoa_pkg.sv =====
// shared types, constants and a character function for the integer to ascii formatter
`default_nettype none

package itoa_pkg;

  localparam int NCELL = 16;
  localparam int DIGW  = 4;
  localparam int BINW  = 32;
  localparam int CHW   = 7;
  localparam int CNTW  = 5;
  localparam int HEXW  = 8;

  localparam logic [2:0] MODE_SDEC = 3'd0;
  localparam logic [2:0] MODE_UDEC = 3'd1;
  localparam logic [2:0] MODE_HEXL = 3'd2;
  localparam logic [2:0] MODE_HEXU = 3'd3;
  localparam logic [2:0] MODE_PTR  = 3'd4;

  localparam logic [CHW-1:0] CHAR_ZERO    = 7'h30;
  localparam logic [CHW-1:0] CHAR_X       = 7'h78;
  localparam logic [CHW-1:0] CHAR_MINUS   = 7'h2d;
  localparam logic [CHW-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHW-1:0] CHAR_UPPER_A = 7'h41;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_DABBLE,
    CELL_SHIFT
  } cell_op_t;

  function automatic logic [CHW-1:0] hex_char(input logic [DIGW-1:0] d, input logic upper);
    logic [CHW-1:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (d < 4'd10) begin
      hex_char = CHAR_ZERO + {3'b000, d};
    end else begin
      hex_char = base + {3'b000, d} - 7'd10;
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/itoa_cell.sv =====
// one digit cell of the conversion chain: load, double-dabble step, digit shift or hold
`default_nettype none

module itoa_cell (
  input  wire                          clk,
  input  itoa_pkg::cell_op_t           op,
  input  wire  [itoa_pkg::DIGW-1:0]    load_digit,
  input  wire  [itoa_pkg::DIGW-1:0]    digit_in,
  input  wire                          bit_in,
  output logic [itoa_pkg::DIGW-1:0]    digit,
  output logic                         bit_out
);

  logic [itoa_pkg::DIGW-1:0] adj;

  // add three before the shift when the digit would overflow past nine
  assign adj     = (digit >= 4'd5) ? (digit + 4'd3) : digit;
  assign bit_out = adj[itoa_pkg::DIGW-1];

  always_ff @(posedge clk) begin
    unique case (op)
      itoa_pkg::CELL_HOLD:   digit <= digit;
      itoa_pkg::CELL_LOAD:   digit <= load_digit;
      itoa_pkg::CELL_DABBLE: digit <= {adj[itoa_pkg::DIGW-2:0], bit_in};
      itoa_pkg::CELL_SHIFT:  digit <= digit_in;
      default:               digit <= digit;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/integer_to_ascii_formatter_unit.sv =====
// top level of the integer to ascii formatter: control, digit chain and output register
//
// Prints one integer per input transfer as ASCII text, most significant character
// first, one character per output transfer; the final character carries last_char
// and the character count. Modes: signed decimal, unsigned decimal, lower and upper
// hex of the low 32 bits, and pointer ("0x" plus lowercase hex of all 64 bits).
// Leading zeros are dropped. Undefined modes are taken and produce nothing.
// Steps per item: the accept, then for decimal modes a double-dabble pass over the
// 32-bit magnitude through the 16-cell digit chain, then the shifting out of each
// suppressed leading zero (up to 15) and the search for the first digit, then the
// emitted characters including the sign or the "0x" prefix, each held by any output
// stall. The next item is accepted as soon as its last character sits in the output
// register.
`default_nettype none
`include "integer_to_ascii_formatter_unit_defines.svh"

module integer_to_ascii_formatter_unit (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  cmd,
  input  wire  [63:0] value,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [6:0]  char_out,
  output logic        last_char,
  output logic [4:0]  char_count
);

  localparam int NCELL = itoa_pkg::NCELL;
  localparam int DIGW  = itoa_pkg::DIGW;
  localparam int BINW  = itoa_pkg::BINW;
  localparam int CNTW  = itoa_pkg::CNTW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_SKIP = 5'b00100,
    S_PRE  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t               state;
  logic [BINW-1:0]      bin;
  logic [4:0]           conv_cnt;
  logic [CNTW-1:0]      remain;
  logic [CNTW-1:0]      cnt;
  logic [1:0]           pre_left;
  logic                 is_ptr;
  logic                 upper;

  logic                 in_fire;
  logic                 adv;
  logic                 emit_now;
  logic                 shift_skip;
  logic                 mode_ok;
  logic                 is_dec;
  logic                 neg;
  logic [BINW-1:0]      low;
  logic [BINW-1:0]      mag;
  itoa_pkg::cell_op_t   op;

  logic [DIGW-1:0]      dig  [NCELL];
  logic                 bout [NCELL];
  logic [DIGW-1:0]      ldig [NCELL];

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign adv        = !out_valid || out_ready;
  assign emit_now   = adv && ((state == S_PRE) || (state == S_EMIT));
  assign mode_ok    = (cmd <= itoa_pkg::MODE_PTR);
  assign is_dec     = (cmd == itoa_pkg::MODE_SDEC) || (cmd == itoa_pkg::MODE_UDEC);
  assign low        = value[BINW-1:0];
  assign neg        = (cmd == itoa_pkg::MODE_SDEC) && low[BINW-1];
  assign mag        = neg ? (32'd0 - low) : low;
  assign shift_skip = (state == S_SKIP) && (dig[NCELL-1] == 4'd0) && (remain > 5'd1);

  always_comb begin
    unique case (state)
      S_IDLE:  op = in_fire ? itoa_pkg::CELL_LOAD : itoa_pkg::CELL_HOLD;
      S_CONV:  op = itoa_pkg::CELL_DABBLE;
      S_SKIP:  op = shift_skip ? itoa_pkg::CELL_SHIFT : itoa_pkg::CELL_HOLD;
      S_EMIT:  op = adv ? itoa_pkg::CELL_SHIFT : itoa_pkg::CELL_HOLD;
      default: op = itoa_pkg::CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    if (i < itoa_pkg::HEXW) begin : g_low
      assign ldig[i] = (cmd == itoa_pkg::MODE_PTR || cmd == itoa_pkg::MODE_HEXL ||
                        cmd == itoa_pkg::MODE_HEXU) ? value[DIGW*i +: DIGW] : 4'd0;
    end else begin : g_high
      assign ldig[i] = (cmd == itoa_pkg::MODE_PTR) ? value[DIGW*i +: DIGW] : 4'd0;
    end

    if (i == 0) begin : g_first
      itoa_cell u_cell (
        .clk        (clk),
        .op         (op),
        .load_digit (ldig[i]),
        .digit_in   (4'd0),
        .bit_in     (bin[BINW-1]),
        .digit      (dig[i]),
        .bit_out    (bout[i])
      );
    end else begin : g_rest
      itoa_cell u_cell (
        .clk        (clk),
        .op         (op),
        .load_digit (ldig[i]),
        .digit_in   (dig[i-1]),
        .bit_in     (bout[i-1]),
        .digit      (dig[i]),
        .bit_out    (bout[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire && mode_ok) begin
            remain   <= CNTW'(NCELL);
            cnt      <= '0;
            upper    <= (cmd == itoa_pkg::MODE_HEXU);
            is_ptr   <= (cmd == itoa_pkg::MODE_PTR);
            pre_left <= (cmd == itoa_pkg::MODE_PTR) ? 2'd2 : (neg ? 2'd1 : 2'd0);
            bin      <= mag;
            conv_cnt <= '0;
            state    <= is_dec ? S_CONV : S_SKIP;
          end
        end
        S_CONV: begin
          bin      <= bin << 1;
          conv_cnt <= conv_cnt + 5'd1;
          if (conv_cnt == 5'(BINW-1)) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (shift_skip) begin
            remain <= remain - 5'd1;
          end else begin
            state <= (pre_left != 2'd0) ? S_PRE : S_EMIT;
          end
        end
        S_PRE: begin
          if (adv) begin
            char_out   <= is_ptr ? ((pre_left == 2'd2) ? itoa_pkg::CHAR_ZERO : itoa_pkg::CHAR_X)
                                 : itoa_pkg::CHAR_MINUS;
            last_char  <= 1'b0;
            char_count <= '0;
            cnt        <= cnt + 5'd1;
            pre_left   <= pre_left - 2'd1;
            if (pre_left == 2'd1) begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (adv) begin
            char_out   <= itoa_pkg::hex_char(dig[NCELL-1], upper);
            remain     <= remain - 5'd1;
            cnt        <= cnt + 5'd1;
            last_char  <= (remain == 5'd1);
            char_count <= (remain == 5'd1) ? (cnt + 5'd1) : 5'd0;
            if (remain == 5'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ITOA_ASSERT_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE && !out_valid), "reset must leave the block idle and empty")
  `ITOA_ASSERT(a_emit_remain, (state == S_EMIT) |-> (remain != 5'd0), "emit with no digit positions left")
  `ITOA_ASSERT(a_last_count, (out_valid && last_char) |-> (char_count != 5'd0 && char_count <= 5'd18), "final character count out of range")
  `ITOA_ASSERT(a_mid_count, (out_valid && !last_char) |-> (char_count == 5'd0), "count shown before final character")
  `ITOA_ASSERT(a_conv_len, (state == S_CONV && conv_cnt != 5'(BINW-1)) |=> (state == S_CONV), "conversion pass ended early")

endmodule

`default_nettype wire
